FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Every check samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property with the project clock and reset
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must hold at every sampled edge
`define ASSERT_ALWAYS(label, cond, msg) \
  `ASSERT_PROP(label, (cond), msg)

`endif

FILE: rtl/core/lfa_pkg.sv
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared sizes, codes and the request type of the allocator's bitmap store.
// ----------------------------------------------------------------------------
package lfa_pkg;

  // Pool size and bitmap organisation (one word per memory row)
  localparam int unsigned NUM_IDS    = 1024;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BIT_W      = $clog2(WORD_W);
  localparam int unsigned NUM_WORDS  = (NUM_IDS + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned IDX_W      = ROW_W + BIT_W;
  localparam int unsigned PTR_W      = IDX_W + 1;

  // Port field widths
  localparam int unsigned ID_FIELD_W = 10;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned FREE_EXT_W = ((IDX_W > ID_FIELD_W) ? IDX_W : ID_FIELD_W) + 1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_NOT_IN_USE = 2'd2
  } status_e;

  // Read and write request towards the bitmap store
  typedef struct packed {
    logic              rd_en;
    logic [ROW_W-1:0]  rd_row;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_row;
    logic [WORD_W-1:0] wr_word;
  } map_req_t;

endpackage

FILE: rtl/core/lfa_ram.sv
// ----------------------------------------------------------------------------
// lfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lfa_ram #(
  parameter  int unsigned Width = 32,
  parameter  int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/lfa_map.sv
// ----------------------------------------------------------------------------
// lfa_map
// In-use bitmap store: one word per row in RAM, with a valid bit per row so
// that reset clears the whole map at once. A row never written reads as zero.
// ----------------------------------------------------------------------------
module lfa_map (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lfa_pkg::map_req_t           req_i,
  output logic [lfa_pkg::WORD_W-1:0]  rd_word_o
);
  import lfa_pkg::*;

  logic [NUM_WORDS-1:0] row_vld_q;
  logic                 rd_vld_q;
  logic [WORD_W-1:0]    ram_rdata;

  // Track written rows and register the valid bit alongside the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_vld_q[req_i.wr_row] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.rd_row];
      end
    end
  end

  lfa_ram #(
    .Width (WORD_W),
    .Depth (NUM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (req_i.wr_row),
    .wdata_i (req_i.wr_word),
    .re_i    (req_i.rd_en),
    .raddr_i (req_i.rd_row),
    .rdata_o (ram_rdata)
  );

  // Mask stale contents of rows not yet written since reset
  assign rd_word_o = rd_vld_q ? ram_rdata : '0;

endmodule

FILE: rtl/core/lfa_scan.sv
// ----------------------------------------------------------------------------
// lfa_scan
// Word scan unit: finds the lowest clear bit of a bitmap word at or above a
// start offset. Shared by the allocate update and the row-by-row search.
// ----------------------------------------------------------------------------
module lfa_scan (
  input  logic [lfa_pkg::WORD_W-1:0] word_i,
  input  logic [lfa_pkg::BIT_W:0]    offset_i,
  output logic                       found_o,
  output logic [lfa_pkg::BIT_W-1:0]  pos_o
);
  import lfa_pkg::*;

  logic [WORD_W-1:0] cand;

  // Free bits at or above the offset
  assign cand    = ~word_i & ({WORD_W{1'b1}} << offset_i);
  assign found_o = |cand;

  // Priority encode towards the lowest free bit
  always_comb begin
    pos_o = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos_o = BIT_W'(i);
      end
    end
  end

endmodule

FILE: rtl/core/lowest_free_id_allocator.sv
// Sequence: read, modify, the scan state once per further bitmap row an allocate searches,
// then done, which waits for a free output register; a full-pool allocate skips to done.
// Throughput: one request at a time, a new transfer the cycle after each result is loaded;
// set by the row-per-cycle search of the bitmap RAM through the shared word scan unit.
// Reset: asynchronous, active low; clears the bitmap row valid bits, so every
// identifier reads free at once, and sets the lowest-free pointer to zero.
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Lowest-free identifier allocator built on an in-use bitmap and a sequencer.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [lfa_pkg::ID_FIELD_W-1:0]   free_id_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lfa_pkg::ID_FIELD_W-1:0]   given_id_o,
  output logic [lfa_pkg::STATUS_W-1:0]     status_o
);
  import lfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MOD  = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_WORDS - 1);
  localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(NUM_IDS);

  state_e                  state_q, state_d;
  op_e                     op_q, op_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [PTR_W-1:0]        lowest_q, lowest_d;
  logic [ROW_W-1:0]        scan_row_q, scan_row_d;
  logic [ID_FIELD_W-1:0]   res_given_q, res_given_d;
  status_e                 res_status_q, res_status_d;
  logic                    out_valid_q, out_valid_d;
  logic [ID_FIELD_W-1:0]   out_given_q, out_given_d;
  status_e                 out_status_q, out_status_d;

  map_req_t                map_req;
  logic [WORD_W-1:0]       rd_word;
  logic [WORD_W-1:0]       scan_word;
  logic [BIT_W:0]          scan_offset;
  logic                    scan_found;
  logic [BIT_W-1:0]        scan_pos;
  logic [ROW_W-1:0]        scan_row_sel;
  logic [PTR_W-1:0]        found_raw;
  logic [PTR_W-1:0]        found_ptr;

  logic [ROW_W-1:0]        idx_row;
  logic [BIT_W-1:0]        idx_bit;
  logic [WORD_W-1:0]       bit_mask;
  logic [FREE_EXT_W-1:0]   free_ext;
  logic                    free_in_range;

  assign idx_row       = idx_q[IDX_W-1:BIT_W];
  assign idx_bit       = idx_q[BIT_W-1:0];
  assign bit_mask      = WORD_W'(1) << idx_bit;
  assign free_ext      = FREE_EXT_W'(free_id_i);
  assign free_in_range = free_ext < FREE_EXT_W'(NUM_IDS);

  lfa_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (map_req),
    .rd_word_o (rd_word)
  );

  lfa_scan u_scan (
    .word_i   (scan_word),
    .offset_i (scan_offset),
    .found_o  (scan_found),
    .pos_o    (scan_pos)
  );

  // Identifier found by the scan unit, clamped to the pool end in a partial row
  assign scan_row_sel = (state_q == S_MOD) ? idx_row : scan_row_q;
  assign found_raw    = PTR_W'({scan_row_sel, scan_pos});
  assign found_ptr    = (found_raw >= PTR_FULL) ? PTR_FULL : found_raw;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    idx_d        = idx_q;
    lowest_d     = lowest_q;
    scan_row_d   = scan_row_q;
    res_given_d  = res_given_q;
    res_status_d = res_status_q;
    out_given_d  = out_given_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    map_req      = '0;
    scan_word    = rd_word;
    scan_offset  = '0;
    in_ready_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d         = op_e'(op_i);
          res_given_d  = '0;
          res_status_d = ST_OK;
          if (op_e'(op_i) == OP_ALLOC) begin
            if (lowest_q == PTR_FULL) begin
              res_status_d = ST_NO_FREE;
              state_d      = S_DONE;
            end else begin
              idx_d   = lowest_q[IDX_W-1:0];
              state_d = S_READ;
            end
          end else begin
            if (!free_in_range) begin
              res_status_d = ST_NOT_IN_USE;
              state_d      = S_DONE;
            end else begin
              idx_d   = IDX_W'(free_ext);
              state_d = S_READ;
            end
          end
        end
      end

      S_READ: begin
        map_req.rd_en  = 1'b1;
        map_req.rd_row = idx_row;
        state_d        = S_MOD;
      end

      S_MOD: begin
        if (op_q == OP_ALLOC) begin
          // Mark the identifier used, then search the rest of its row
          map_req.wr_en   = 1'b1;
          map_req.wr_row  = idx_row;
          map_req.wr_word = rd_word | bit_mask;
          res_given_d     = ID_FIELD_W'(idx_q);
          scan_word       = rd_word | bit_mask;
          scan_offset     = {1'b0, idx_bit} + (BIT_W + 1)'(1);
          if (scan_found) begin
            lowest_d = found_ptr;
            state_d  = S_DONE;
          end else if (idx_row == LAST_ROW) begin
            lowest_d = PTR_FULL;
            state_d  = S_DONE;
          end else begin
            scan_row_d     = idx_row + ROW_W'(1);
            map_req.rd_en  = 1'b1;
            map_req.rd_row = idx_row + ROW_W'(1);
            state_d        = S_SCAN;
          end
        end else begin
          // Release the identifier if it is held, and pull the pointer down
          if ((rd_word & bit_mask) == '0) begin
            res_status_d = ST_NOT_IN_USE;
          end else begin
            map_req.wr_en   = 1'b1;
            map_req.wr_row  = idx_row;
            map_req.wr_word = rd_word & ~bit_mask;
            if (PTR_W'(idx_q) < lowest_q) begin
              lowest_d = PTR_W'(idx_q);
            end
          end
          state_d = S_DONE;
        end
      end

      S_SCAN: begin
        // Check one row per cycle while the next row is being read
        if (scan_found) begin
          lowest_d = found_ptr;
          state_d  = S_DONE;
        end else if (scan_row_q == LAST_ROW) begin
          lowest_d = PTR_FULL;
          state_d  = S_DONE;
        end else begin
          scan_row_d     = scan_row_q + ROW_W'(1);
          map_req.rd_en  = 1'b1;
          map_req.rd_row = scan_row_q + ROW_W'(1);
        end
      end

      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_given_d  = res_given_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lowest_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lowest_q    <= lowest_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    idx_q        <= idx_d;
    scan_row_q   <= scan_row_d;
    res_given_q  <= res_given_d;
    res_status_q <= res_status_d;
    out_given_q  <= out_given_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign given_id_o  = out_given_q;
  assign status_o    = out_status_q;

endmodule

FILE: rtl/core/lfa_checker.sv
// ----------------------------------------------------------------------------
// lfa_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [lfa_pkg::ID_FIELD_W-1:0] given_id_o,
  input logic [lfa_pkg::STATUS_W-1:0]   status_o
);
  import lfa_pkg::*;

  // A stalled result holds its payload
  `ASSERT_PROP(a_out_hold,
    (out_valid_o && !out_ready_i |=> out_valid_o && $stable(given_id_o) && $stable(status_o)),
    "stalled result changed")

  // Only defined status codes are reported
  `ASSERT_ALWAYS(a_status_code,
    (!out_valid_o || status_o == ST_OK || status_o == ST_NO_FREE || status_o == ST_NOT_IN_USE),
    "undefined status code")

  // An identifier is handed out only with a successful allocate
  `ASSERT_ALWAYS(a_given_zero,
    (!out_valid_o || status_o == ST_OK || given_id_o == '0),
    "identifier with failing status")

  // One request at a time: no transfer in the cycle after an accepted one
  `ASSERT_PROP(a_one_at_a_time,
    (in_valid_i && in_ready_o |=> !in_ready_o),
    "ready right after transfer")

endmodule

bind lowest_free_id_allocator lfa_checker u_lfa_checker (.*);
